[hw/rtl/point_to_aim_line_distance_macros.svh]
// assertion macros for the point to aim line distance block
// used by the top level; expects clk and rst_n in scope
`ifndef POINT_TO_AIM_LINE_DISTANCE_MACROS_SVH
`define POINT_TO_AIM_LINE_DISTANCE_MACROS_SVH

// same-cycle implication, off during reset
`define PTALD_ASSERT_IMPLY(name, cond, concl, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (concl)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PTALD_ASSERT_NEXT(name, cond, concl, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (concl)) \
        else $error(msg);

`endif

[hw/rtl/ptald_pkg.sv]
// shared types, widths and constants of the aim line distance pipeline
// no dependencies
`default_nettype none

package ptald_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int ANGLE_W = 26;
    localparam int DIST_W  = 34;

    // angle units are 1/65536 degree
    localparam logic signed [26:0] ANGLE_FULL     = 27'sd23592960;
    localparam logic signed [26:0] ANGLE_TWO_FULL = 27'sd47185920;
    localparam logic [24:0]        ANGLE_QUARTER  = 25'd5898240;

    // cordic datapath
    localparam int CORDIC_STEPS = 22;
    localparam int TRIG_W       = 34;
    localparam int PHASE_W      = 25;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30     = 34'sd1073741824;

    // square root datapath
    localparam int RAD_W  = 72;
    localparam int ROOT_W = 36;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  x;
        logic signed [TRIG_W-1:0]  y;
        logic signed [PHASE_W-1:0] z;
    } cordic_t;

    // data riding along the cordic stages
    typedef struct packed {
        quad_t                    quad_p;
        quad_t                    quad_y;
        logic                     zero_p;
        logic                     zero_y;
        logic signed [DIFF_W-1:0] ex;
        logic signed [DIFF_W-1:0] ey;
        logic signed [DIFF_W-1:0] ez;
    } side_t;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic signed [PHASE_W-1:0] atan_step(input int unsigned i);
        logic signed [PHASE_W-1:0] v;
        case (i)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            16:      v = 25'sd57;
            17:      v = 25'sd29;
            18:      v = 25'sd14;
            19:      v = 25'sd7;
            20:      v = 25'sd4;
            21:      v = 25'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ptald_sqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on ptald_pkg for radicand and root widths
`default_nettype none

module ptald_sqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [ptald_pkg::RAD_W-1:0]  radicand,
    output logic      [ptald_pkg::ROOT_W-1:0] root
);
    import ptald_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_step
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W+1:0]  rem_sh;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  rem_sub;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = radicand;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            // bring down the next bit pair and try the subtraction
            assign rem_sh  = {rem_in, rad_in[RAD_W-1 -: 2]};
            assign trial   = {2'b00, root_in, 2'b01};
            assign ge      = (rem_sh >= trial);
            assign rem_sub = rem_sh - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                    root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                    rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

[hw/rtl/point_to_aim_line_distance.sv]
// top level: perpendicular distance from a point to an aim line
// depends on ptald_pkg, ptald_sqrt and point_to_aim_line_distance_macros.svh
//
//  channel | handshake          | beat contents
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | origin xyz, pitch_angle, yaw_angle, point xyz
//  out     | out_valid/out_stall| line_distance
//
// one beat enters per cycle unless in_stall is high
// the depth is set by the 22 cordic stages, the 36-stage square roots and the
// 34-stage divider; every stage holds when the output register is full and stalled
// reset clears only the valid bits, payload registers are not reset
// in_stall is high exactly while the output register is full and out_stall is high
`default_nettype none

`include "point_to_aim_line_distance_macros.svh"

module point_to_aim_line_distance (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] origin_x,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] origin_y,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] origin_z,
    input  wire logic signed [ptald_pkg::ANGLE_W-1:0] pitch_angle,
    input  wire logic signed [ptald_pkg::ANGLE_W-1:0] yaw_angle,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [ptald_pkg::COORD_W-1:0] point_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic             [ptald_pkg::DIST_W-1:0]  line_distance
);
    import ptald_pkg::*;

    localparam int MAG_W   = 32;
    localparam int EMAG_W  = 33;
    localparam int TERM_W  = 35;
    localparam int CROSS_W = 36;
    localparam int CMAG_W  = 35;
    localparam int ND_W    = 33;
    localparam int DIV_STEPS = 34;
    localparam int unsigned E_SEL [0:5] = '{1, 2, 2, 0, 0, 1};
    localparam int unsigned D_SEL [0:5] = '{2, 1, 0, 2, 1, 0};

    // wrap an angle into [0, 360) degrees
    function automatic logic [24:0] reduce_angle(input logic signed [ANGLE_W-1:0] a);
        logic signed [26:0] ext;
        logic signed [26:0] res;
        ext = {a[ANGLE_W-1], a};
        if (ext >= ANGLE_FULL)
            res = ext - ANGLE_FULL;
        else if (ext >= 27'sd0)
            res = ext;
        else if (ext >= -ANGLE_FULL)
            res = ext + ANGLE_FULL;
        else
            res = ext + ANGLE_TWO_FULL;
        return res[24:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag_trig(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W-1:0] n;
        n = v[TRIG_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    // round a q30 product to nearest, halves away from zero (on magnitudes)
    function automatic logic [TERM_W-2:0] round_q30(input logic [64:0] p);
        logic [64:0] s;
        s = p + (65'd1 << 29);
        return s[63:30];
    endfunction

    // global advance: everything moves unless the output is full and stalled
    logic adv;
    logic out_valid_reg;
    logic [DIST_W-1:0] line_distance_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign line_distance = line_distance_reg;

    // stage a: differences and angle wrap
    logic a_vld_reg;
    logic signed [DIFF_W-1:0] a_ex_reg, a_ey_reg, a_ez_reg;
    logic [24:0] a_mp_reg, a_my_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ex_reg <= DIFF_W'(point_x) - DIFF_W'(origin_x);
            a_ey_reg <= DIFF_W'(point_y) - DIFF_W'(origin_y);
            a_ez_reg <= DIFF_W'(point_z) - DIFF_W'(origin_z);
            a_mp_reg <= reduce_angle(pitch_angle);
            a_my_reg <= reduce_angle(yaw_angle);
        end
    end

    // stage b: quadrant split, cordic seed in slot zero
    logic    cor_vld_reg [0:CORDIC_STEPS];
    cordic_t cor_p_reg   [0:CORDIC_STEPS];
    cordic_t cor_y_reg   [0:CORDIC_STEPS];
    side_t   side_reg    [0:CORDIC_STEPS];

    quad_t       qp, qy;
    logic [22:0] rp, ry;

    always_comb
    begin
        if (a_mp_reg < ANGLE_QUARTER)
        begin
            qp = QUAD_0; rp = a_mp_reg[22:0];
        end
        else if (a_mp_reg < 2 * ANGLE_QUARTER)
        begin
            qp = QUAD_1; rp = 23'(a_mp_reg - ANGLE_QUARTER);
        end
        else if (a_mp_reg < 3 * ANGLE_QUARTER)
        begin
            qp = QUAD_2; rp = 23'(a_mp_reg - 2 * ANGLE_QUARTER);
        end
        else
        begin
            qp = QUAD_3; rp = 23'(a_mp_reg - 3 * ANGLE_QUARTER);
        end
        if (a_my_reg < ANGLE_QUARTER)
        begin
            qy = QUAD_0; ry = a_my_reg[22:0];
        end
        else if (a_my_reg < 2 * ANGLE_QUARTER)
        begin
            qy = QUAD_1; ry = 23'(a_my_reg - ANGLE_QUARTER);
        end
        else if (a_my_reg < 3 * ANGLE_QUARTER)
        begin
            qy = QUAD_2; ry = 23'(a_my_reg - 2 * ANGLE_QUARTER);
        end
        else
        begin
            qy = QUAD_3; ry = 23'(a_my_reg - 3 * ANGLE_QUARTER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cor_p_reg[0] <= '{x: CORDIC_GAIN, y: '0, z: {2'b00, rp}};
            cor_y_reg[0] <= '{x: CORDIC_GAIN, y: '0, z: {2'b00, ry}};
            side_reg[0]  <= '{quad_p: qp, quad_y: qy, zero_p: (rp == '0),
                              zero_y: (ry == '0), ex: a_ex_reg, ey: a_ey_reg,
                              ez: a_ez_reg};
        end
    end

    // cordic rotation stages, one micro-rotation each
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_cordic
            cordic_t np, ny;

            always_comb
            begin
                np = cor_p_reg[i];
                ny = cor_y_reg[i];
                if (!cor_p_reg[i].z[PHASE_W-1])
                begin
                    np.x = cor_p_reg[i].x - (cor_p_reg[i].y >>> i);
                    np.y = cor_p_reg[i].y + (cor_p_reg[i].x >>> i);
                    np.z = cor_p_reg[i].z - atan_step(i);
                end
                else
                begin
                    np.x = cor_p_reg[i].x + (cor_p_reg[i].y >>> i);
                    np.y = cor_p_reg[i].y - (cor_p_reg[i].x >>> i);
                    np.z = cor_p_reg[i].z + atan_step(i);
                end
                if (!cor_y_reg[i].z[PHASE_W-1])
                begin
                    ny.x = cor_y_reg[i].x - (cor_y_reg[i].y >>> i);
                    ny.y = cor_y_reg[i].y + (cor_y_reg[i].x >>> i);
                    ny.z = cor_y_reg[i].z - atan_step(i);
                end
                else
                begin
                    ny.x = cor_y_reg[i].x + (cor_y_reg[i].y >>> i);
                    ny.y = cor_y_reg[i].y - (cor_y_reg[i].x >>> i);
                    ny.z = cor_y_reg[i].z + atan_step(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cor_p_reg[i+1] <= np;
                    cor_y_reg[i+1] <= ny;
                    side_reg[i+1]  <= side_reg[i];
                end
            end
        end
    endgenerate

    // stage r: exact zero residue and quadrant rotation
    logic r_vld_reg;
    logic signed [TRIG_W-1:0] r_cp_reg, r_sp_reg, r_cy_reg, r_sy_reg;
    logic signed [DIFF_W-1:0] r_ex_reg, r_ey_reg, r_ez_reg;
    logic signed [TRIG_W-1:0] xp, yp, xy, yy;
    logic signed [TRIG_W-1:0] cp_n, sp_n, cy_n, sy_n;
    side_t sd;

    always_comb
    begin
        sd = side_reg[CORDIC_STEPS];
        xp = sd.zero_p ? ONE_Q30 : cor_p_reg[CORDIC_STEPS].x;
        yp = sd.zero_p ? '0      : cor_p_reg[CORDIC_STEPS].y;
        xy = sd.zero_y ? ONE_Q30 : cor_y_reg[CORDIC_STEPS].x;
        yy = sd.zero_y ? '0      : cor_y_reg[CORDIC_STEPS].y;
        case (sd.quad_p)
            QUAD_1:  begin cp_n = -yp; sp_n = xp;  end
            QUAD_2:  begin cp_n = -xp; sp_n = -yp; end
            QUAD_3:  begin cp_n = yp;  sp_n = -xp; end
            default: begin cp_n = xp;  sp_n = yp;  end
        endcase
        case (sd.quad_y)
            QUAD_1:  begin cy_n = -yy; sy_n = xy;  end
            QUAD_2:  begin cy_n = -xy; sy_n = -yy; end
            QUAD_3:  begin cy_n = yy;  sy_n = -xy; end
            default: begin cy_n = xy;  sy_n = yy;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_cp_reg <= cp_n;
            r_sp_reg <= sp_n;
            r_cy_reg <= cy_n;
            r_sy_reg <= sy_n;
            r_ex_reg <= sd.ex;
            r_ey_reg <= sd.ey;
            r_ez_reg <= sd.ez;
        end
    end

    // stages m1..m3: direction x and y as rounded q30 products
    logic m1_vld_reg, m2_vld_reg, m3_vld_reg;
    logic [MAG_W-1:0] m1_cp_reg, m1_cy_reg, m1_sy_reg;
    logic m1_nx_reg, m1_ny_reg, m2_nx_reg, m2_ny_reg;
    logic signed [TRIG_W-1:0] m1_dz_reg, m2_dz_reg, m3_dz_reg;
    logic [63:0] m2_px_reg, m2_py_reg;
    logic signed [TRIG_W-1:0] m3_dx_reg, m3_dy_reg;
    logic signed [DIFF_W-1:0] m1_e_reg [0:2];
    logic signed [DIFF_W-1:0] m2_e_reg [0:2];
    logic signed [DIFF_W-1:0] m3_e_reg [0:2];
    logic [TERM_W-2:0] rx, ry_q;

    assign rx   = round_q30({1'b0, m2_px_reg});
    assign ry_q = round_q30({1'b0, m2_py_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_cp_reg <= mag_trig(r_cp_reg);
            m1_cy_reg <= mag_trig(r_cy_reg);
            m1_sy_reg <= mag_trig(r_sy_reg);
            m1_nx_reg <= r_cp_reg[TRIG_W-1] ^ r_cy_reg[TRIG_W-1];
            m1_ny_reg <= r_cp_reg[TRIG_W-1] ^ r_sy_reg[TRIG_W-1];
            m1_dz_reg <= -r_sp_reg;
            m1_e_reg[0] <= r_ex_reg;
            m1_e_reg[1] <= r_ey_reg;
            m1_e_reg[2] <= r_ez_reg;

            m2_px_reg <= {32'b0, m1_cp_reg} * {32'b0, m1_cy_reg};
            m2_py_reg <= {32'b0, m1_cp_reg} * {32'b0, m1_sy_reg};
            m2_nx_reg <= m1_nx_reg;
            m2_ny_reg <= m1_ny_reg;
            m2_dz_reg <= m1_dz_reg;
            m2_e_reg  <= m1_e_reg;

            m3_dx_reg <= m2_nx_reg ? -{1'b0, rx[TRIG_W-2:0]} : {1'b0, rx[TRIG_W-2:0]};
            m3_dy_reg <= m2_ny_reg ? -{1'b0, ry_q[TRIG_W-2:0]}
                                   : {1'b0, ry_q[TRIG_W-2:0]};
            m3_dz_reg <= m2_dz_reg;
            m3_e_reg  <= m2_e_reg;
        end
    end

    // stages c1..c5: cross product of offset and direction
    logic c1_vld_reg, c2_vld_reg, c3_vld_reg, c4_vld_reg, c5_vld_reg;
    logic [EMAG_W-1:0] c1_em_reg [0:2];
    logic              c1_en_reg [0:2];
    logic [MAG_W-1:0]  c1_dm_reg [0:2];
    logic              c1_dn_reg [0:2];
    logic [MAG_W-1:0]  c2_dm_reg [0:2];
    logic [MAG_W-1:0]  c3_dm_reg [0:2];
    logic [MAG_W-1:0]  c4_dm_reg [0:2];
    logic [MAG_W-1:0]  c5_dm_reg [0:2];
    logic [64:0]       c2_p_reg  [0:5];
    logic              c2_n_reg  [0:5];
    logic signed [TERM_W-1:0]  c3_t_reg [0:5];
    logic signed [CROSS_W-1:0] c4_c_reg [0:2];
    logic [CMAG_W-1:0]         c5_cm_reg [0:2];
    logic signed [TRIG_W-1:0]  dvec [0:2];

    assign dvec[0] = m3_dx_reg;
    assign dvec[1] = m3_dy_reg;
    assign dvec[2] = m3_dz_reg;

    genvar j;
    generate
        for (j = 0; j < 3; j++)
        begin : g_axis
            logic signed [DIFF_W-1:0] e_abs;
            logic signed [CROSS_W-1:0] c_abs;

            assign e_abs = m3_e_reg[j][DIFF_W-1] ? -m3_e_reg[j] : m3_e_reg[j];
            assign c_abs = c4_c_reg[j][CROSS_W-1] ? -c4_c_reg[j] : c4_c_reg[j];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    c1_em_reg[j] <= e_abs;
                    c1_en_reg[j] <= m3_e_reg[j][DIFF_W-1];
                    c1_dm_reg[j] <= mag_trig(dvec[j]);
                    c1_dn_reg[j] <= dvec[j][TRIG_W-1];
                    c2_dm_reg[j] <= c1_dm_reg[j];
                    c3_dm_reg[j] <= c2_dm_reg[j];
                    c4_dm_reg[j] <= c3_dm_reg[j];
                    c5_dm_reg[j] <= c4_dm_reg[j];
                    c4_c_reg[j]  <= {c3_t_reg[2*j][TERM_W-1], c3_t_reg[2*j]}
                                  - {c3_t_reg[2*j+1][TERM_W-1], c3_t_reg[2*j+1]};
                    c5_cm_reg[j] <= c_abs[CMAG_W-1:0];
                end
            end
        end

        for (j = 0; j < 6; j++)
        begin : g_term
            logic [TERM_W-2:0] rt;

            assign rt = round_q30(c2_p_reg[j]);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    c2_p_reg[j] <= {32'b0, c1_em_reg[E_SEL[j]]}
                                 * {33'b0, c1_dm_reg[D_SEL[j]]};
                    c2_n_reg[j] <= c1_en_reg[E_SEL[j]] ^ c1_dn_reg[D_SEL[j]];
                    c3_t_reg[j] <= c2_n_reg[j] ? -{1'b0, rt} : {1'b0, rt};
                end
            end
        end
    endgenerate

    // stages s1, s2: sums of squares, wide squares split in partial products
    logic s1_vld_reg, s2_vld_reg;
    logic [33:0] s1_hh_reg [0:2];
    logic [34:0] s1_hl_reg [0:2];
    logic [35:0] s1_ll_reg [0:2];
    logic [63:0] s1_dd_reg [0:2];
    logic [RAD_W-1:0] s2_sc_reg, s2_sd_reg;
    logic [RAD_W-1:0] sum_c, sum_d;

    generate
        for (j = 0; j < 3; j++)
        begin : g_square
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s1_hh_reg[j] <= {17'b0, c5_cm_reg[j][34:18]}
                                  * {17'b0, c5_cm_reg[j][34:18]};
                    s1_hl_reg[j] <= {18'b0, c5_cm_reg[j][34:18]}
                                  * {17'b0, c5_cm_reg[j][17:0]};
                    s1_ll_reg[j] <= {18'b0, c5_cm_reg[j][17:0]}
                                  * {18'b0, c5_cm_reg[j][17:0]};
                    s1_dd_reg[j] <= {32'b0, c5_dm_reg[j]} * {32'b0, c5_dm_reg[j]};
                end
            end
        end
    endgenerate

    always_comb
    begin
        sum_c = '0;
        sum_d = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum_c = sum_c + (RAD_W'(s1_hh_reg[k]) << 36) + (RAD_W'(s1_hl_reg[k]) << 19)
                  + RAD_W'(s1_ll_reg[k]);
            sum_d = sum_d + RAD_W'(s1_dd_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sc_reg <= sum_c;
            s2_sd_reg <= sum_d;
        end
    end

    // square roots of both sums
    logic sq_vld_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] nc, nd_root;

    ptald_sqrt u_sqrt_cross (
        .clk      (clk),
        .en       (adv),
        .radicand (s2_sc_reg),
        .root     (nc)
    );

    ptald_sqrt u_sqrt_dir (
        .clk      (clk),
        .en       (adv),
        .radicand (s2_sd_reg),
        .root     (nd_root)
    );

    // stage d0: saturation test and divider seed
    logic d0_vld_reg, d0_sat_reg;
    logic [ND_W-1:0] d0_nd_reg, d0_rem_reg;
    logic [DIV_STEPS-1:0] d0_num_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_sat_reg <= ({4'b0, nc} >= {3'b0, nd_root[ND_W-1:0], 4'b0});
            d0_nd_reg  <= nd_root[ND_W-1:0];
            d0_rem_reg <= {1'b0, nc[ROOT_W-1:4]};
            d0_num_reg <= {nc[3:0], 30'b0};
        end
    end

    // restoring divider, one quotient bit per stage
    logic                 dv_vld_reg [0:DIV_STEPS-1];
    logic                 dv_sat_reg [0:DIV_STEPS-1];
    logic [ND_W-1:0]      dv_nd_reg  [0:DIV_STEPS-1];
    logic [ND_W-1:0]      dv_rem_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] dv_num_reg [0:DIV_STEPS-1];
    logic [DIST_W-1:0]    dv_q_reg   [0:DIV_STEPS-1];

    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_div
            logic                 sat_in;
            logic [ND_W-1:0]      nd_in, rem_in;
            logic [DIV_STEPS-1:0] num_in;
            logic [DIST_W-1:0]    q_in;
            logic [ND_W:0]        rem_sh;
            logic [ND_W:0]        rem_sub;
            logic                 ge;

            if (i == 0)
            begin : g_first
                assign sat_in = d0_sat_reg;
                assign nd_in  = d0_nd_reg;
                assign rem_in = d0_rem_reg;
                assign num_in = d0_num_reg;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign sat_in = dv_sat_reg[i-1];
                assign nd_in  = dv_nd_reg[i-1];
                assign rem_in = dv_rem_reg[i-1];
                assign num_in = dv_num_reg[i-1];
                assign q_in   = dv_q_reg[i-1];
            end

            assign rem_sh  = {rem_in, num_in[DIV_STEPS-1]};
            assign ge      = (rem_sh >= {1'b0, nd_in});
            assign rem_sub = rem_sh - {1'b0, nd_in};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_sat_reg[i] <= sat_in;
                    dv_nd_reg[i]  <= nd_in;
                    dv_rem_reg[i] <= ge ? rem_sub[ND_W-1:0] : rem_sh[ND_W-1:0];
                    dv_num_reg[i] <= {num_in[DIV_STEPS-2:0], 1'b0};
                    dv_q_reg[i]   <= {q_in[DIST_W-2:0], ge};
                end
            end
        end
    endgenerate

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_distance_reg <= dv_sat_reg[DIV_STEPS-1] ? DIST_MAX : dv_q_reg[DIV_STEPS-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            r_vld_reg     <= 1'b0;
            m1_vld_reg    <= 1'b0;
            m2_vld_reg    <= 1'b0;
            m3_vld_reg    <= 1'b0;
            c1_vld_reg    <= 1'b0;
            c2_vld_reg    <= 1'b0;
            c3_vld_reg    <= 1'b0;
            c4_vld_reg    <= 1'b0;
            c5_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            d0_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++)
                cor_vld_reg[k] <= 1'b0;
            for (int k = 0; k < ROOT_W; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg      <= in_valid;
            cor_vld_reg[0] <= a_vld_reg;
            for (int k = 1; k <= CORDIC_STEPS; k++)
                cor_vld_reg[k] <= cor_vld_reg[k-1];
            r_vld_reg      <= cor_vld_reg[CORDIC_STEPS];
            m1_vld_reg     <= r_vld_reg;
            m2_vld_reg     <= m1_vld_reg;
            m3_vld_reg     <= m2_vld_reg;
            c1_vld_reg     <= m3_vld_reg;
            c2_vld_reg     <= c1_vld_reg;
            c3_vld_reg     <= c2_vld_reg;
            c4_vld_reg     <= c3_vld_reg;
            c5_vld_reg     <= c4_vld_reg;
            s1_vld_reg     <= c5_vld_reg;
            s2_vld_reg     <= s1_vld_reg;
            sq_vld_reg[0]  <= s2_vld_reg;
            for (int k = 1; k < ROOT_W; k++)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            d0_vld_reg     <= sq_vld_reg[ROOT_W-1];
            dv_vld_reg[0]  <= d0_vld_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            out_valid_reg  <= dv_vld_reg[DIV_STEPS-1];
        end
    end

    // checks
    `PTALD_ASSERT_IMPLY(a_cordic_converged, cor_vld_reg[CORDIC_STEPS],
        (cor_p_reg[CORDIC_STEPS].z <= 25'sd64) && (cor_p_reg[CORDIC_STEPS].z >= -25'sd64),
        "cordic residual phase out of range")
    `PTALD_ASSERT_IMPLY(a_dir_unit, sq_vld_reg[ROOT_W-1],
        nd_root >= (36'd1 << 29), "direction length far from unit")
    `PTALD_ASSERT_NEXT(a_hold_on_stall, in_stall,
        $stable(d0_vld_reg) && $stable(dv_vld_reg[DIV_STEPS-1]), "pipeline moved while held")

endmodule

`default_nettype wire
